// File: rtl/himl_pkg.sv
package himl_pkg;

    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] first_address;
        logic [15:0] last_address;
        logic [31:0] word_data;
        logic [15:0] line_number;
        logic        last;
    } out_t;

    // One finished line (or an end-of-image marker) handed from parser to sequencer
    typedef struct packed {
        logic        is_done;
        logic        shape_ok;
        logic        len_ok;
        logic        star;
        logic [15:0] address;
        logic [31:0] data;
    } himl_rec_t;

    localparam logic [15:0] MAX_ADDRESS_RESET = 16'd4095;
    localparam logic [15:0] WORD_BYTES        = 16'd4;
    localparam logic [15:0] LINE_COUNT_MAX    = 16'hFFFF;

endpackage

// File: rtl/hex_memory_image_loader.sv
// Hex memory image loader.
// s_* channel: one transaction per character (char_byte), or an end-of-file
// marker (end_of_file = 1). Lines are "AAAA: DDDDDDDD" with an optional '*'
// in column 15; a character is taken every cycle while s_ready is high.
// m_* channel: per good line a fill transaction (only after a star line) and
// then a store transaction; an error or the final end-of-file gives one
// status transaction, after which all input is swallowed until reset.
// cfg_* channel: writes max_address, the highest accepted byte address.
// A newline is registered into the line queue, then into the output register,
// before its first result shows on m_*. Throughput: one character per cycle
// while s_ready is high; a good line gives at most two results from 15 or more
// characters, so the parser never waits on the result side unless m_ready is held low.
// A two-entry line queue sits between parser and sequencer; while m_ready is
// low the output register holds, the queue fills and then s_ready drops.
// Reset (aresetn low, synchronous) clears the line state, line counter to 1,
// max_address to 4095, and empties the queue and output register.
module hex_memory_image_loader import himl_pkg::*; #(
    parameter int ADDRESS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    logic      q_full;
    logic      q_push;
    himl_rec_t q_push_rec;
    logic      q_pop;
    logic      q_valid;
    himl_rec_t q_head;

    himl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_rec   (q_push_rec)
    );

    himl_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (q_head)
    );

    himl_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_rec     (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/himl_front.sv
module himl_front import himl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    input  logic      q_full,
    output logic      q_push,
    output himl_rec_t q_rec
);

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [4:0] COL_MAX    = 5'd31;
    localparam logic [4:0] COL_COLON  = 5'd4;
    localparam logic [4:0] COL_SEP    = 5'd5;
    localparam logic [4:0] COL_ADDR_L = 5'd3;
    localparam logic [4:0] COL_DATA_F = 5'd6;
    localparam logic [4:0] COL_DATA_L = 5'd13;
    localparam logic [4:0] COL_STAR   = 5'd15;
    localparam logic [4:0] LEN_MIN    = 5'd15;
    localparam logic [4:0] LEN_MAX    = 5'd17;

    logic [4:0]  col_reg, col_next;
    logic [15:0] addr_reg, addr_next;
    logic [31:0] data_reg, data_next;
    logic        shape_reg, shape_next;
    logic        star_reg, star_next;

    logic        accept;
    logic [4:0]  hex;
    logic        shape_c;
    logic        star_c;
    logic [15:0] addr_c;
    logic [31:0] data_c;

    // {valid, value}
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign hex     = hex_lookup(s_data.char_byte);

    // Column checks for the current character
    always_comb begin
        shape_c = shape_reg;
        star_c  = star_reg;
        addr_c  = addr_reg;
        data_c  = data_reg;
        if (col_reg <= COL_ADDR_L || (col_reg >= COL_DATA_F && col_reg <= COL_DATA_L)) begin
            if (!hex[4]) begin
                shape_c = 1'b0;
            end else if (col_reg <= COL_ADDR_L) begin
                addr_c = {addr_reg[11:0], hex[3:0]};
            end else begin
                data_c = {data_reg[27:0], hex[3:0]};
            end
        end else if (col_reg == COL_COLON) begin
            if (s_data.char_byte != CH_COLON) shape_c = 1'b0;
        end else if (col_reg == COL_SEP) begin
            if (s_data.char_byte != CH_SPACE && s_data.char_byte != CH_TAB) shape_c = 1'b0;
        end else if (col_reg == COL_STAR) begin
            if (s_data.char_byte == CH_STAR) begin
                star_c = 1'b1;
            end else if (s_data.char_byte != CH_SPACE && s_data.char_byte != CH_TAB
                         && s_data.char_byte != CH_NL && s_data.char_byte != CH_VT
                         && s_data.char_byte != CH_FF && s_data.char_byte != CH_CR) begin
                shape_c = 1'b0;
            end
        end
    end

    always_comb begin
        col_next   = col_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        shape_next = shape_reg;
        star_next  = star_reg;
        q_push     = 1'b0;
        q_rec      = '0;
        if (accept) begin
            if (s_data.end_of_file) begin
                q_push         = 1'b1;
                q_rec.is_done  = (col_reg == 5'd0);
                q_rec.shape_ok = shape_reg;
                q_rec.len_ok   = (col_reg >= LEN_MIN) && (col_reg <= LEN_MAX);
                q_rec.star     = star_reg;
                q_rec.address  = addr_reg;
                q_rec.data     = data_reg;
                col_next   = '0;
                addr_next  = '0;
                data_next  = '0;
                shape_next = 1'b1;
                star_next  = 1'b0;
            end else if (s_data.char_byte == CH_NL) begin
                // length counts the newline: col + 1 in 15..17
                q_push         = 1'b1;
                q_rec.shape_ok = shape_c;
                q_rec.len_ok   = (col_reg >= LEN_MIN - 5'd1) && (col_reg <= LEN_MAX - 5'd1);
                q_rec.star     = star_c;
                q_rec.address  = addr_c;
                q_rec.data     = data_c;
                col_next   = '0;
                addr_next  = '0;
                data_next  = '0;
                shape_next = 1'b1;
                star_next  = 1'b0;
            end else begin
                addr_next  = addr_c;
                data_next  = data_c;
                shape_next = shape_c;
                star_next  = star_c;
                if (col_reg < COL_MAX) col_next = col_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            addr_reg  <= '0;
            data_reg  <= '0;
            shape_reg <= 1'b1;
            star_reg  <= 1'b0;
        end else begin
            col_reg   <= col_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            shape_reg <= shape_next;
            star_reg  <= star_next;
        end
    end

endmodule

// File: rtl/himl_fifo.sv
module himl_fifo import himl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  himl_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output himl_rec_t head_rec
);

    himl_rec_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/himl_back.sv
module himl_back import himl_pkg::*; #(
    parameter int ADDRESS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        q_valid,
    input  himl_rec_t   q_rec,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS) - 1);

    logic [15:0] max_addr_reg;
    logic        first_reg, first_next;
    logic [15:0] prev_addr_reg, prev_addr_next;
    logic [31:0] prev_data_reg, prev_data_next;
    logic        prev_star_reg, prev_star_next;
    logic [15:0] line_cnt_reg, line_cnt_next;
    logic        stopped_reg, stopped_next;
    logic        phase_reg, phase_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic [15:0] limit;
    logic [16:0] addr17;
    logic [16:0] prev_plus4;
    logic [16:0] prev_plus8;
    logic        bad;
    logic        has_fill;
    logic        load;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_addr_reg <= MAX_ADDRESS_RESET;
        end else if (cfg_valid) begin
            max_addr_reg <= cfg_data;
        end
    end

    // Shape, length, limit and sequence check of the line at the queue head
    always_comb begin
        limit      = max_addr_reg & ADDR_MASK;
        addr17     = {1'b0, q_rec.address};
        prev_plus4 = {1'b0, prev_addr_reg} + 17'({WORD_BYTES});
        prev_plus8 = {1'b0, prev_addr_reg} + 17'({WORD_BYTES, 1'b0});
        bad = !q_rec.shape_ok || !q_rec.len_ok || (q_rec.address > limit);
        if (!bad) begin
            if (first_reg) begin
                bad = (q_rec.address != 16'd0);
            end else if (prev_star_reg) begin
                bad = (addr17 < prev_plus8) || (q_rec.address[1:0] != 2'd0);
            end else begin
                bad = (addr17 != prev_plus4);
            end
        end
        has_fill = !q_rec.is_done && !bad && !first_reg && prev_star_reg;
    end

    assign load  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = load && (stopped_reg || !has_fill || phase_reg);

    always_comb begin
        first_next     = first_reg;
        prev_addr_next = prev_addr_reg;
        prev_data_next = prev_data_reg;
        prev_star_next = prev_star_reg;
        line_cnt_next  = line_cnt_reg;
        stopped_next   = stopped_reg;
        phase_next     = phase_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        if (!m_valid_reg || m_ready) begin
            m_valid_next = load && !stopped_reg;
        end
        if (load && !stopped_reg) begin
            m_data_next.line_number = line_cnt_reg;
            if (has_fill && !phase_reg) begin
                // first emit the gap left after a star line
                m_data_next.kind          = KIND_FILL;
                m_data_next.first_address = prev_plus4[15:0];
                m_data_next.last_address  = q_rec.address - WORD_BYTES;
                m_data_next.word_data     = prev_data_reg;
                m_data_next.last          = 1'b0;
                phase_next                = 1'b1;
            end else begin
                phase_next       = 1'b0;
                m_data_next.last = 1'b1;
                if (q_rec.is_done || bad) begin
                    m_data_next.kind          = q_rec.is_done ? KIND_DONE : KIND_ERROR;
                    m_data_next.first_address = '0;
                    m_data_next.last_address  = '0;
                    m_data_next.word_data     = '0;
                    stopped_next              = 1'b1;
                end else begin
                    m_data_next.kind          = KIND_STORE;
                    m_data_next.first_address = q_rec.address;
                    m_data_next.last_address  = q_rec.address;
                    m_data_next.word_data     = q_rec.data;
                    prev_addr_next            = q_rec.address;
                    prev_data_next            = q_rec.data;
                    prev_star_next            = q_rec.star;
                    first_next                = 1'b0;
                    if (line_cnt_reg != LINE_COUNT_MAX) line_cnt_next = line_cnt_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg     <= 1'b1;
            prev_addr_reg <= '0;
            prev_data_reg <= '0;
            prev_star_reg <= 1'b0;
            line_cnt_reg  <= 16'd1;
            stopped_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            first_reg     <= first_next;
            prev_addr_reg <= prev_addr_next;
            prev_data_reg <= prev_data_next;
            prev_star_reg <= prev_star_next;
            line_cnt_reg  <= line_cnt_next;
            stopped_reg   <= stopped_next;
            phase_reg     <= phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    a_stopped_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    a_phase_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (q_valid && !stopped_reg))
        else $error("fill emitted but its store line is gone");

    a_fill_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_FILL) |-> !m_data_reg.last)
        else $error("fill result flagged as last");

    a_store_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && m_data_reg.kind == KIND_FILL) |=>
        (m_valid_reg && m_data_reg.kind == KIND_STORE))
        else $error("fill not followed by its store");

endmodule

// File: tb/tb_hex_memory_image_loader.sv
`timescale 1ns / 1ps

module tb_hex_memory_image_loader;
    import himl_pkg::*;

    localparam int unsigned RUN_LIMIT     = 400000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned RANDOM_ITEMS  = 1300;
    localparam int unsigned PRINT_CAP     = 40;

    localparam int unsigned LINE_MIN     = 15;
    localparam int unsigned LINE_MAX     = 17;
    localparam int unsigned COL_COLON    = 4;
    localparam int unsigned COL_SEP      = 5;
    localparam int unsigned COL_STAR     = 15;
    localparam int unsigned COL_SATURATE = 31;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] DIGIT_0  = 8'h30;
    localparam logic [7:0] DIGIT_9  = 8'h39;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_F  = 8'h46;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_F  = 8'h66;

    localparam logic [15:0] LIMIT_AT_RESET = 16'd4095;
    localparam logic [15:0] LIMIT_TOP      = 16'hFFFF;
    localparam logic [15:0] LINE_NO_TOP    = 16'hFFFF;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_mode_e;

    typedef enum int unsigned {
        END_CLEAN,
        END_OPEN_LINE,
        END_BAD_HEX,
        END_BAD_COLON,
        END_BAD_SEPARATOR,
        END_BAD_STAR_COLUMN,
        END_SHORT_LINE,
        END_LONG_LINE,
        END_OVER_LIMIT,
        END_BAD_SEQUENCE,
        END_TOP_ADDRESS
    } end_case_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;

    hex_memory_image_loader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("hex_memory_image_loader regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Loader state as the line parser sees it
    // ---------------------------------------------------------------
    logic [15:0] addr_limit    = LIMIT_AT_RESET;
    logic [4:0]  col_cnt       = '0;
    logic [15:0] addr_acc      = '0;
    logic [31:0] data_acc      = '0;
    logic        shape_good    = 1'b1;
    logic        star_now      = 1'b0;
    logic        first_pending = 1'b1;
    logic [15:0] prev_addr     = '0;
    logic [31:0] prev_data     = '0;
    logic        prev_star     = 1'b0;
    logic [15:0] line_no       = 16'd1;
    logic        halted        = 1'b0;

    out_t        image_ops_q[$];
    int unsigned error_count = 0;

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int nibble_of(logic [7:0] c);
        if (c >= DIGIT_0 && c <= DIGIT_9) return int'(c - DIGIT_0);
        if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
        if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
        return -1;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic void push_op(kind_t k, logic [15:0] first_a, logic [15:0] last_a,
                                    logic [31:0] data, logic last_flag);
        out_t r;
        r.kind          = k;
        r.first_address = first_a;
        r.last_address  = last_a;
        r.word_data     = data;
        r.line_number   = line_no;
        r.last          = last_flag;
        image_ops_q.push_back(r);
    endfunction

    function automatic void clear_line_state();
        col_cnt    = '0;
        addr_acc   = '0;
        data_acc   = '0;
        shape_good = 1'b1;
        star_now   = 1'b0;
    endfunction

    function automatic void close_line(int unsigned len);
        int unsigned a;
        int unsigned prev;
        bit          bad;
        a    = 32'(addr_acc);
        prev = 32'(prev_addr);
        bad  = !shape_good || len < LINE_MIN || len > LINE_MAX || a > 32'(addr_limit);
        if (!bad) begin
            if (first_pending)
                bad = a != 0;
            else if (prev_star)
                bad = a < prev + 8 || (a % 4) != 0;
            else
                bad = a != prev + 4;
        end
        if (bad) begin
            push_op(KIND_ERROR, '0, '0, '0, 1'b1);
            halted = 1'b1;
            clear_line_state();
            return;
        end
        // a star line leaves a hole up to this address, filled with its word
        if (!first_pending && prev_star)
            push_op(KIND_FILL, prev_addr + 16'd4, addr_acc - 16'd4, prev_data, 1'b0);
        push_op(KIND_STORE, addr_acc, addr_acc, data_acc, 1'b1);
        prev_addr     = addr_acc;
        prev_data     = data_acc;
        prev_star     = star_now;
        first_pending = 1'b0;
        if (line_no != LINE_NO_TOP)
            line_no++;
        clear_line_state();
    endfunction

    function automatic void parse_item(in_t it);
        int unsigned col;
        int          nib;
        logic [7:0]  c;
        if (halted)
            return;
        if (it.end_of_file) begin
            if (col_cnt == 0) begin
                push_op(KIND_DONE, '0, '0, '0, 1'b1);
                halted = 1'b1;
            end else begin
                close_line(32'(col_cnt));
            end
            return;
        end
        c   = it.char_byte;
        col = 32'(col_cnt);
        nib = nibble_of(c);
        if (col < COL_COLON || (col > COL_SEP && col < LINE_MIN - 1)) begin
            if (nib < 0)
                shape_good = 1'b0;
            else if (col < COL_COLON)
                addr_acc = {addr_acc[11:0], nib[3:0]};
            else
                data_acc = {data_acc[27:0], nib[3:0]};
        end else if (col == COL_COLON) begin
            if (c != CH_COLON) shape_good = 1'b0;
        end else if (col == COL_SEP) begin
            if (c != CH_SPACE && c != CH_TAB) shape_good = 1'b0;
        end else if (col == COL_STAR) begin
            if (c == CH_STAR) star_now = 1'b1;
            else if (!is_blank(c)) shape_good = 1'b0;
        end
        if (c == CH_NL)
            close_line(col + 1);
        else if (col_cnt < COL_SATURATE)
            col_cnt++;
    endfunction

    task automatic check_op(out_t got);
        out_t want;
        if (image_ops_q.size() == 0) begin
            flag_error($sformatf("result with nothing pending: kind %0d line %0d",
                                 got.kind, got.line_number));
            return;
        end
        want = image_ops_q.pop_front();
        if (got.kind !== want.kind)
            flag_error($sformatf("kind: got %0d expected %0d (line %0d)",
                                 got.kind, want.kind, want.line_number));
        if (got.first_address !== want.first_address)
            flag_error($sformatf("first_address: got %h expected %h (line %0d)",
                                 got.first_address, want.first_address, want.line_number));
        if (got.last_address !== want.last_address)
            flag_error($sformatf("last_address: got %h expected %h (line %0d)",
                                 got.last_address, want.last_address, want.line_number));
        if (got.word_data !== want.word_data)
            flag_error($sformatf("word_data: got %h expected %h (line %0d)",
                                 got.word_data, want.word_data, want.line_number));
        if (got.line_number !== want.line_number)
            flag_error($sformatf("line_number: got %0d expected %0d",
                                 got.line_number, want.line_number));
        if (got.last !== want.last)
            flag_error($sformatf("last: got %b expected %b (line %0d)",
                                 got.last, want.last, want.line_number));
    endtask

    // sample every channel on the edge; predict before comparing
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                addr_limit = cfg_data;
            if (s_valid && s_ready)
                parse_item(s_data);
            if (m_valid && m_ready)
                check_op(m_data);
        end
    end

    // ---------------------------------------------------------------
    // Result side back-pressure
    // ---------------------------------------------------------------
    rx_mode_e    rx_mode       = RX_OPEN;
    int unsigned rx_left       = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;

    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_RHYTHM));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (rx_left % 3 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Character stream driver
    // ---------------------------------------------------------------
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    logic [7:0]  line_chars[$];
    logic [15:0] image_addr  = '0;
    logic        image_star  = 1'b0;
    logic        image_fresh = 1'b1;

    task automatic send_item(logic [7:0] c, logic eof);
        in_t         it;
        int unsigned gap;
        it.char_byte   = c;
        it.end_of_file = eof;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_chars();
        foreach (line_chars[i])
            send_item(line_chars[i], 1'b0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10)
            return DIGIT_0 + n;
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + n - 8'd10;
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
        return b;
    endfunction

    // len is the line length with its newline; star needs len 17
    function automatic void compose_line(logic [15:0] addr, logic [31:0] data, bit star,
                                         int unsigned len);
        line_chars.delete();
        for (int i = 3; i >= 0; i--)
            line_chars.push_back(hex_char(addr[i*4 +: 4]));
        line_chars.push_back(CH_COLON);
        line_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        for (int i = 7; i >= 0; i--)
            line_chars.push_back(hex_char(data[i*4 +: 4]));
        if (len > LINE_MIN)
            line_chars.push_back(any_but_newline());
        if (len == LINE_MAX) begin
            if (star) begin
                line_chars.push_back(CH_STAR);
            end else begin
                case ($urandom_range(0, 4))
                    0:       line_chars.push_back(CH_SPACE);
                    1:       line_chars.push_back(CH_TAB);
                    2:       line_chars.push_back(CH_VT);
                    3:       line_chars.push_back(CH_FF);
                    default: line_chars.push_back(CH_CR);
                endcase
            end
        end
        line_chars.push_back(CH_NL);
    endfunction

    function automatic logic [15:0] next_address(bit allow_jump);
        int unsigned a;
        if (image_fresh)
            return '0;
        if (!image_star)
            return image_addr + 16'd4;
        a = image_addr + 8;
        if (allow_jump)
            a += 4 * (($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 3));
        return a[15:0];
    endfunction

    task automatic send_line(logic [15:0] addr, logic [31:0] data, bit star,
                             int unsigned len);
        compose_line(addr, data, star, len);
        send_chars();
        image_addr  = addr;
        image_star  = star;
        image_fresh = 1'b0;
    endtask

    task automatic send_random_line();
        bit          star;
        logic [31:0] data;
        star = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        send_line(next_address(1), data, star, star ? LINE_MAX : $urandom_range(LINE_MIN, LINE_MAX));
    endtask

    // drop valid, let the pipeline empty, then write the address limit
    task automatic write_max_address(logic [15:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (image_ops_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_zero_limit_first_line();
        write_max_address('0);
        send_line(next_address(0), 32'hFFFF_FFFF, 1'b0, LINE_MIN);
    endtask

    task automatic test_star_fill();
        write_max_address(LIMIT_TOP);
        send_line(next_address(0), $urandom, 1'b1, LINE_MAX);
        send_line(next_address(0), '0, 1'b0, LINE_MAX - 1);
    endtask

    task automatic test_random_image(int unsigned target);
        int unsigned lo;
        while (items_sent < target) begin
            lo = image_addr + 32'h4000;
            if (lo > LIMIT_TOP)
                lo = LIMIT_TOP;
            write_max_address(($urandom_range(0, 2) == 0) ? LIMIT_TOP
                                                          : 16'($urandom_range(lo, LIMIT_TOP)));
            repeat ($urandom_range(6, 18)) send_random_line();
        end
    endtask

    task automatic test_long_hold();
        hold_requests++;
        repeat (12) send_random_line();
    endtask

    task automatic test_image_end();
        end_case_e   how;
        logic [7:0]  b;
        logic [15:0] a;
        int unsigned n;
        bit          star;
        how = end_case_e'($urandom_range(END_CLEAN, END_TOP_ADDRESS));
        a   = next_address(1);
        if (how == END_OVER_LIMIT) begin
            a = next_address(0);
            write_max_address(a - 16'd1);
        end else begin
            write_max_address(LIMIT_TOP);
        end
        line_chars.delete();
        case (how)
            END_CLEAN: ;
            END_OPEN_LINE: begin
                star = 1'($urandom_range(0, 1));
                compose_line(a, $urandom, star,
                             star ? LINE_MAX : $urandom_range(LINE_MIN + 1, LINE_MAX));
                void'(line_chars.pop_back());
            end
            END_BAD_HEX: begin
                compose_line(a, $urandom, 1'b0, LINE_MIN + 1);
                n = $urandom_range(0, 11);
                if (n >= COL_COLON)
                    n += 2;
                do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0 || b == CH_NL);
                line_chars[n] = b;
            end
            END_BAD_COLON: begin
                compose_line(a, $urandom, 1'b0, LINE_MIN);
                do b = 8'($urandom_range(0, 255)); while (b == CH_COLON || b == CH_NL);
                line_chars[COL_COLON] = b;
            end
            END_BAD_SEPARATOR: begin
                compose_line(a, $urandom, 1'b0, LINE_MIN);
                do b = 8'($urandom_range(0, 255));
                while (b == CH_SPACE || b == CH_TAB || b == CH_NL);
                line_chars[COL_SEP] = b;
            end
            END_BAD_STAR_COLUMN: begin
                compose_line(a, $urandom, 1'b0, LINE_MAX);
                do b = 8'($urandom_range(0, 255)); while (b == CH_STAR || is_blank(b));
                line_chars[COL_STAR] = b;
            end
            END_SHORT_LINE: begin
                compose_line(a, $urandom, 1'b0, LINE_MIN);
                n = $urandom_range(0, LINE_MIN - 2);
                while (line_chars.size() > n)
                    void'(line_chars.pop_back());
                line_chars.push_back(CH_NL);
            end
            END_LONG_LINE: begin
                compose_line(a, $urandom, 1'b0, LINE_MAX);
                void'(line_chars.pop_back());
                n = $urandom_range(LINE_MAX, 40);
                while (line_chars.size() < n)
                    line_chars.push_back(any_but_newline());
                line_chars.push_back(CH_NL);
            end
            END_OVER_LIMIT:
                compose_line(a, $urandom, 1'b0, LINE_MIN + 1);
            END_BAD_SEQUENCE: begin
                if (image_star)
                    a = image_addr + ($urandom_range(0, 1) ? 16'd4 : 16'd10);
                else
                    a = image_addr + ($urandom_range(0, 1) ? 16'd8 : 16'd0);
                compose_line(a, $urandom, 1'b0, LINE_MIN + 1);
            end
            default: begin
                // top word of memory leaves no room for a successor line
                send_line(a, $urandom, 1'b1, LINE_MAX);
                send_line(16'hFFFC, $urandom, 1'b0, LINE_MIN + 1);
                compose_line(16'($urandom_range(0, 16383) * 4), $urandom, 1'b0, LINE_MIN);
            end
        endcase
        send_chars();
        if (how == END_CLEAN || how == END_OPEN_LINE)
            send_item(8'($urandom_range(0, 255)), 1'b1);
        if (how == END_OPEN_LINE)
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_stopped_input();
        repeat (32) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    int unsigned drain_wait = 0;
    out_t        leftover;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_limit_first_line();
        test_star_fill();
        test_random_image(500);
        test_long_hold();
        test_random_image(RANDOM_ITEMS);
        test_image_end();
        test_stopped_input();

        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            drain_wait++;
        end while (image_ops_q.size() != 0 && drain_wait < DRAIN_LIMIT);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        while (image_ops_q.size() != 0) begin
            leftover = image_ops_q.pop_front();
            flag_error($sformatf("missing result: kind %0d line %0d",
                                 leftover.kind, leftover.line_number));
        end

        if (error_count == 0)
            $display("hex_memory_image_loader regression: pass");
        else
            $display("hex_memory_image_loader regression: fail");
        $finish;
    end

endmodule
